### rtl/pixel_plot_framebuffer_macros.svh
`ifndef PIXEL_PLOT_FRAMEBUFFER_MACROS_SVH
`define PIXEL_PLOT_FRAMEBUFFER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define PPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define PPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ppf_pkg.sv
`timescale 1ns / 1ps

package ppf_pkg;

    typedef enum logic [1:0] {
        MODE_DATA = 2'd0,
        MODE_CMD  = 2'd1,
        MODE_TRIG = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CMD_DRAW   = 3'd0,
        CMD_LOAD_X = 3'd1,
        CMD_LOAD_Y = 3'd2,
        CMD_CLEAR  = 3'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

    localparam logic CFG_CMD_HIGH = 1'b0;
    localparam logic CFG_PAL_RGBI = 1'b1;

    localparam logic [7:0] LVL_FULL = 8'hff;
    localparam logic [7:0] LVL_DIM  = 8'h40;
    localparam logic [7:0] LVL_OFF  = 8'h00;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    function automatic logic [7:0] colour_level(input logic [3:0] pix, input logic rgbi,
                                                input logic [1:0] ch);
        logic [7:0] lvl;
        if (pix[ch]) begin
            lvl = LVL_FULL;
        end else if (rgbi && pix[3]) begin
            lvl = LVL_DIM;
        end else begin
            lvl = LVL_OFF;
        end
        return lvl;
    endfunction

endpackage

### rtl/pixel_plot_framebuffer.sv
`timescale 1ns / 1ps
// A data, command or trigger item's result is valid in the cycle after acceptance;
//   a read's registered store data is loaded in ST_READ once the output is free.
// One non-read item per cycle while the output is free; tready is low in ST_READ.
// A clear command holds tready low through ST_CLEAR and ST_DONE while the store port
//   writes one pixel a cycle, then reports clear_done as the trigger item's result.
// Reset: synchronous, active low; a sweep then zeroes all 2^(X_BITS+Y_BITS) addresses.

module pixel_plot_framebuffer #(
    parameter int X_BITS = 8,
    parameter int Y_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // write_value[7:0], line_level[8], read_x[16:9],
                                    // read_y[24:17], zero fill
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // pixel_value[3:0], red[11:4], green[19:12],
                                    // blue[27:20], zero fill
    output logic        o_m_tuser   // clear_done
);

    localparam int AW = X_BITS + Y_BITS;

    ppf_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [3:0]        mem_wdata;
    logic [3:0]        mem_rd_data;
    logic [3:0]        pixel_value;
    logic [7:0]        red, green, blue;

    ppf_ctrl #(
        .X_BITS (X_BITS),
        .Y_BITS (Y_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_mode        (ppf_pkg::t_mode'(i_s_tuser)),
        .i_write_value (i_s_tdata[7:0]),
        .i_line_level  (i_s_tdata[8]),
        .i_read_x      (i_s_tdata[16:9]),
        .i_read_y      (i_s_tdata[24:17]),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_pixel_value (pixel_value),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_clear_done  (o_m_tuser),
        .o_mem_ctl     (mem_ctl),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rd_data (mem_rd_data)
    );

    ppf_store #(
        .AW (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wdata   (mem_wdata),
        .o_rd_data (mem_rd_data)
    );

    assign o_m_tdata = {4'b0000, blue, green, red, pixel_value};

endmodule

### rtl/ppf_store.sv
`timescale 1ns / 1ps

module ppf_store #(
    parameter int AW = 16
) (
    input  logic              i_clk,
    input  ppf_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [3:0]        i_wdata,
    output logic [3:0]        o_rd_data
);

    logic [3:0] r_mem [2**AW];
    logic [3:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ppf_ctrl.sv
`timescale 1ns / 1ps
`include "pixel_plot_framebuffer_macros.svh"

module ppf_ctrl #(
    parameter int X_BITS = 8,
    parameter int Y_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic                       i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ppf_pkg::t_mode             i_mode,
    input  logic [7:0]                 i_write_value,
    input  logic                       i_line_level,
    input  logic [7:0]                 i_read_x,
    input  logic [7:0]                 i_read_y,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [3:0]                 o_pixel_value,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic                       o_clear_done,
    output ppf_pkg::t_mem_ctl          o_mem_ctl,
    output logic [X_BITS+Y_BITS-1:0]   o_mem_addr,
    output logic [3:0]                 o_mem_wdata,
    input  logic [3:0]                 i_mem_rd_data
);

    localparam int AW = X_BITS + Y_BITS;

    ppf_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_cnt;
    logic [3:0]        r_fill;
    logic              r_report;
    logic [7:0]        r_data;
    ppf_pkg::t_cmd     r_cmd;
    logic [X_BITS-1:0] r_cx, n_cx;
    logic [Y_BITS-1:0] r_cy, n_cy;
    logic              r_cfg_hi;
    logic              r_cfg_pal;
    logic              r_out_valid;
    logic [3:0]        r_pix;
    logic [7:0]        r_red, r_green, r_blue;
    logic              r_done;

    logic              out_free;
    logic              in_ready;
    logic              accept;
    logic              run;
    logic              do_draw;
    logic              do_clear;
    logic              load_res;
    logic              res_read;
    logic              sweep_end;
    logic [X_BITS-1:0] rx;
    logic [Y_BITS-1:0] ry;
    ppf_pkg::t_mem_ctl mem_ctl;

    assign out_free  = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && in_ready;
    assign run       = accept && (i_mode == ppf_pkg::MODE_TRIG) && !i_line_level;
    assign do_draw   = run && (r_cmd == ppf_pkg::CMD_DRAW);
    assign do_clear  = run && (r_cmd == ppf_pkg::CMD_CLEAR);
    assign sweep_end = (r_cnt == {AW{1'b1}});
    assign rx        = X_BITS'(i_read_x);
    assign ry        = Y_BITS'(i_read_y);

    // Step the cursor for a draw
    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        if (r_data[4]) begin
            n_cx = r_data[6] ? r_cx - X_BITS'(1) : r_cx + X_BITS'(1);
        end
        if (r_data[5]) begin
            n_cy = r_data[7] ? r_cy - Y_BITS'(1) : r_cy + Y_BITS'(1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppf_pkg::ST_CLEAR: begin
                if (sweep_end) begin
                    n_state = r_report ? ppf_pkg::ST_DONE : ppf_pkg::ST_IDLE;
                end
            end
            ppf_pkg::ST_IDLE: begin
                if (do_clear) begin
                    n_state = ppf_pkg::ST_CLEAR;
                end else if (accept && i_mode == ppf_pkg::MODE_READ) begin
                    n_state = ppf_pkg::ST_READ;
                end
            end
            ppf_pkg::ST_READ,
            ppf_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ppf_pkg::ST_IDLE;
                end
            end
            default: n_state = ppf_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        in_ready    = 1'b0;
        mem_ctl     = '0;
        o_mem_addr  = {ry, rx};
        o_mem_wdata = r_data[3:0];
        load_res    = 1'b0;
        res_read    = 1'b0;
        case (r_state)
            ppf_pkg::ST_CLEAR: begin
                mem_ctl.wr  = 1'b1;
                o_mem_addr  = r_cnt;
                o_mem_wdata = r_fill;
            end
            ppf_pkg::ST_IDLE: begin
                in_ready   = out_free;
                mem_ctl.wr = do_draw;
                mem_ctl.rd = accept && (i_mode == ppf_pkg::MODE_READ);
                if (do_draw) begin
                    o_mem_addr = {n_cy, n_cx};
                end
                // A clear reports only once its sweep has finished
                load_res   = accept && (i_mode != ppf_pkg::MODE_READ) && !do_clear;
            end
            ppf_pkg::ST_READ: begin
                load_res = out_free;
                res_read = 1'b1;
            end
            ppf_pkg::ST_DONE: begin
                load_res = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppf_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_report    <= 1'b0;
            r_data      <= '0;
            r_cmd       <= ppf_pkg::CMD_DRAW;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cfg_hi    <= 1'b0;
            r_cfg_pal   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ppf_pkg::ST_CLEAR) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (do_clear) begin
                r_cnt    <= '0;
                r_fill   <= r_data[3:0];
                r_report <= 1'b1;
            end
            if (accept && i_mode == ppf_pkg::MODE_DATA) begin
                r_data <= i_write_value;
            end
            if (accept && i_mode == ppf_pkg::MODE_CMD) begin
                r_cmd <= ppf_pkg::t_cmd'(r_cfg_hi ? i_write_value[5:3] : i_write_value[2:0]);
            end
            if (do_draw) begin
                r_cx <= n_cx;
                r_cy <= n_cy;
            end
            if (run && r_cmd == ppf_pkg::CMD_LOAD_X) begin
                r_cx <= X_BITS'(r_data);
            end
            if (run && r_cmd == ppf_pkg::CMD_LOAD_Y) begin
                r_cy <= Y_BITS'(r_data);
            end
            if (i_cfg_we && i_cfg_addr == ppf_pkg::CFG_CMD_HIGH) begin
                r_cfg_hi <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == ppf_pkg::CFG_PAL_RGBI) begin
                r_cfg_pal <= i_cfg_wdata;
            end
            if (load_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_done <= (r_state == ppf_pkg::ST_DONE);
            if (res_read) begin
                r_pix   <= i_mem_rd_data;
                r_red   <= ppf_pkg::colour_level(i_mem_rd_data, r_cfg_pal, ppf_pkg::CH_RED);
                r_green <= ppf_pkg::colour_level(i_mem_rd_data, r_cfg_pal, ppf_pkg::CH_GREEN);
                r_blue  <= ppf_pkg::colour_level(i_mem_rd_data, r_cfg_pal, ppf_pkg::CH_BLUE);
            end else begin
                r_pix   <= '0;
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pix;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_clear_done  = r_done;
    assign o_mem_ctl     = mem_ctl;

    `PPF_ASSERT_NOW(a_no_wr_rd_clash, mem_ctl.wr, !mem_ctl.rd,
        "store written and read in one cycle")
    `PPF_ASSERT_NEXT(a_read_waits, accept && i_mode == ppf_pkg::MODE_READ,
        r_state == ppf_pkg::ST_READ && !o_in_ready, "read item not held for store data")
    `PPF_ASSERT_NEXT(a_clear_starts, do_clear,
        r_state == ppf_pkg::ST_CLEAR && r_cnt == '0 && r_report, "clear sweep not started")
    `PPF_ASSERT_NEXT(a_done_reported, r_state == ppf_pkg::ST_DONE && out_free,
        r_out_valid && r_done && r_state == ppf_pkg::ST_IDLE, "clear completion not reported")

endmodule

### tb/ppf_checker.sv
`timescale 1ns / 1ps

module ppf_checker
    import ppf_pkg::*;
#(
    parameter int X_BITS = 8,
    parameter int Y_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // write_value[7:0], line_level[8], read_x[16:9],
                                    // read_y[24:17], zero fill
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,  // pixel_value[3:0], red[11:4], green[19:12],
                                    // blue[27:20], zero fill
    input  logic        i_m_tuser,  // clear_done
    output int          o_fail_count,
    output int          o_pending
);

    localparam int STORE_DEPTH = 1 << (X_BITS + Y_BITS);

    typedef struct packed {
        logic [3:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       clear_done;
    } t_plot_result;

    logic [3:0]        pixels [STORE_DEPTH];
    logic [7:0]        data_reg;
    logic [2:0]        cmd_reg;
    logic [X_BITS-1:0] cur_x;
    logic [Y_BITS-1:0] cur_y;
    logic              cmd_high;
    logic              pal_rgbi;
    t_plot_result      awaited_results [$];
    int                mismatches = 0;

    // Apply one accepted item to the shadow plotter and return what it should report
    function automatic t_plot_result plot_step(input t_mode mode, input logic [7:0] wv,
                                               input logic lvl, input logic [7:0] rx,
                                               input logic [7:0] ry);
        t_plot_result res;
        logic [3:0]   pix;
        logic         dim;
        res = '0;
        case (mode)
            MODE_DATA: data_reg = wv;
            MODE_CMD:  cmd_reg = cmd_high ? wv[5:3] : wv[2:0];
            MODE_TRIG: begin
                if (!lvl) begin
                    case (cmd_reg)
                        CMD_DRAW: begin
                            if (data_reg[4]) begin
                                cur_x = data_reg[6] ? cur_x - X_BITS'(1) : cur_x + X_BITS'(1);
                            end
                            if (data_reg[5]) begin
                                cur_y = data_reg[7] ? cur_y - Y_BITS'(1) : cur_y + Y_BITS'(1);
                            end
                            pixels[{cur_y, cur_x}] = data_reg[3:0];
                        end
                        CMD_LOAD_X: cur_x = X_BITS'(data_reg);
                        CMD_LOAD_Y: cur_y = Y_BITS'(data_reg);
                        CMD_CLEAR: begin
                            for (int i = 0; i < STORE_DEPTH; i++) begin
                                pixels[i] = data_reg[3:0];
                            end
                            res.clear_done = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            MODE_READ: begin
                pix       = pixels[{ry[Y_BITS-1:0], rx[X_BITS-1:0]}];
                dim       = pal_rgbi && pix[3];
                res.pixel = pix;
                res.red   = pix[0] ? LVL_FULL : (dim ? LVL_DIM : LVL_OFF);
                res.green = pix[1] ? LVL_FULL : (dim ? LVL_DIM : LVL_OFF);
                res.blue  = pix[2] ? LVL_FULL : (dim ? LVL_DIM : LVL_OFF);
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_plot_result want;
        t_plot_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                pixels[i] = 4'd0;
            end
            data_reg = 8'd0;
            cmd_reg  = CMD_DRAW;
            cur_x    = '0;
            cur_y    = '0;
            cmd_high = 1'b0;
            pal_rgbi = 1'b0;
            awaited_results.delete();
        end else begin
            // Compare before pushing so that a stray result is never paired with a new item
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[3:0], i_m_tdata[11:4], i_m_tdata[19:12],
                       i_m_tdata[27:20], i_m_tuser};
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected item: pix=%h r=%h g=%h b=%h done=%b",
                                 got.pixel, got.red, got.green, got.blue, got.clear_done);
                    end
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.pixel !== got.pixel || want.red !== got.red ||
                        want.green !== got.green || want.blue !== got.blue ||
                        want.clear_done !== got.clear_done) begin
                        if (mismatches < 10) begin
                            $display("mismatch: want pix=%h r=%h g=%h b=%h done=%b",
                                     want.pixel, want.red, want.green, want.blue,
                                     want.clear_done);
                            $display("          got  pix=%h r=%h g=%h b=%h done=%b",
                                     got.pixel, got.red, got.green, got.blue,
                                     got.clear_done);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(plot_step(t_mode'(i_s_tuser), i_s_tdata[7:0],
                                                    i_s_tdata[8], i_s_tdata[16:9],
                                                    i_s_tdata[24:17]));
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_CMD_HIGH) begin
                    cmd_high = i_cfg_wdata;
                end else begin
                    pal_rgbi = i_cfg_wdata;
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ppf_pkg::*;

    localparam int WATCHDOG_LIMIT = 262144;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_addr  = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [31:0] i_s_tdata   = 32'd0;
    logic [1:0]  i_s_tuser   = MODE_DATA;
    logic        i_m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    int          fail_count;
    int          pending;
    int          stall_cycles   = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          clears_left    = 0;
    logic [2:0]  shadow_cmd     = CMD_DRAW;
    logic        cmd_high       = 1'b0;

    pixel_plot_framebuffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    ppf_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // A clear or the reset sweep stalls for one full store pass; anything far beyond is a hang
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] r8();
        return 8'($urandom);
    endfunction

    function automatic logic rbit();
        return 1'($urandom);
    endfunction

    // Place a command in the field the plotter currently decodes, noise elsewhere
    function automatic logic [7:0] cmd_byte(input logic [2:0] cmd);
        logic [7:0] b;
        b = r8();
        if (cmd_high) begin
            b[5:3] = cmd;
        end else begin
            b[2:0] = cmd;
        end
        return b;
    endfunction

    task automatic send_item(input t_mode mode, input logic [7:0] wv, input logic lvl,
                             input logic [7:0] rx, input logic [7:0] ry);
        logic fire_lvl;
        fire_lvl = lvl;
        // Hold clears to a budget: each one stalls the bus for a whole store pass
        if (mode == MODE_TRIG && !lvl && shadow_cmd == CMD_CLEAR) begin
            if (clears_left > 0) begin
                clears_left--;
            end else begin
                fire_lvl = 1'b1;
            end
        end
        if (mode == MODE_CMD) begin
            shadow_cmd = cmd_high ? wv[5:3] : wv[2:0];
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {7'd0, ry, rx, fire_lvl, wv};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic hi, input logic rgbi);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_CMD_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_PAL_RGBI;
        i_cfg_wdata <= rgbi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        cmd_high = hi;
    endtask

    // Place the cursor, draw a short run and read back around the start point
    task automatic draw_run();
        logic [7:0] x0;
        logic [7:0] y0;
        int         steps;
        int         peeks;
        x0    = r8();
        y0    = r8();
        steps = $urandom_range(8, 1);
        peeks = $urandom_range(6, 1);
        send_item(MODE_DATA, x0, rbit(), r8(), r8());
        send_item(MODE_CMD, cmd_byte(CMD_LOAD_X), rbit(), r8(), r8());
        send_item(MODE_TRIG, r8(), 1'b0, r8(), r8());
        send_item(MODE_DATA, y0, rbit(), r8(), r8());
        send_item(MODE_CMD, cmd_byte(CMD_LOAD_Y), rbit(), r8(), r8());
        send_item(MODE_TRIG, r8(), 1'b0, r8(), r8());
        send_item(MODE_DATA, r8(), rbit(), r8(), r8());
        send_item(MODE_CMD, cmd_byte(CMD_DRAW), rbit(), r8(), r8());
        repeat (steps) begin
            send_item(MODE_TRIG, r8(), ($urandom_range(9) == 0), r8(), r8());
        end
        repeat (peeks) begin
            send_item(MODE_READ, r8(), rbit(), x0 + 8'($urandom_range(16)) - 8'd8,
                      y0 + 8'($urandom_range(16)) - 8'd8);
        end
    endtask

    task automatic clear_run();
        send_item(MODE_DATA, r8(), rbit(), r8(), r8());
        send_item(MODE_CMD, cmd_byte(CMD_CLEAR), rbit(), r8(), r8());
        send_item(MODE_TRIG, r8(), 1'b0, r8(), r8());
        send_item(MODE_READ, r8(), rbit(), r8(), r8());
        send_item(MODE_READ, r8(), rbit(), r8(), r8());
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic hi,
                             input logic rgbi, input int count);
        int goal;
        int pick;
        set_config(hi, rgbi);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        clears_left    = 1;
        goal           = items_sent + count;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                draw_run();
            end else if (pick < 66 && clears_left > 0) begin
                clear_run();
            end else begin
                repeat (4) send_item(t_mode'(2'($urandom_range(3))), r8(), rbit(), r8(), r8());
            end
            if ($urandom_range(29) == 0) begin
                drain();
            end
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        clears_left = 1;
        send_item(MODE_READ, 8'h00, 1'b1, 8'h00, 8'h00);
        send_item(MODE_READ, 8'hff, 1'b0, 8'hff, 8'hff);
        send_item(MODE_DATA, 8'hff, 1'b1, 8'hff, 8'hff);
        send_item(MODE_CMD, 8'hf9, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_CMD, 8'hfa, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'hff, 1'b0, 8'hff, 8'hff);
        // Both cursors at the top: stepping up wraps to the origin
        send_item(MODE_DATA, 8'h3f, 1'b0, 8'h00, 8'h00);
        send_item(MODE_CMD, 8'hf8, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b1, 8'h00, 8'h00);
        send_item(MODE_DATA, 8'hf7, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_DATA, 8'h09, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_CMD, 8'h07, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_READ, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_READ, 8'h00, 1'b0, 8'hff, 8'hff);
        send_item(MODE_DATA, 8'h0c, 1'b0, 8'h00, 8'h00);
        send_item(MODE_CMD, 8'h03, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_READ, 8'h00, 1'b0, 8'h80, 8'h7f);
        // Command field moves up; low bits now read as a clear and must be ignored
        set_config(1'b1, 1'b1);
        send_item(MODE_CMD, 8'h0b, 1'b0, 8'h00, 8'h00);
        send_item(MODE_TRIG, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(MODE_READ, 8'h00, 1'b0, 8'h00, 8'h00);

        run_phase(0, 0, 1'b0, 1'b0, 310);
        run_phase(51, 0, 1'b1, 1'b0, 310);
        run_phase(0, 51, 1'b0, 1'b1, 310);
        run_phase(31, 31, 1'b1, 1'b1, 310);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
